[rtl/atadr_pkg.sv]
package atadr_pkg;

  // Default sizing
  localparam int BUFFER_BYTES_DEF = 32768;
  localparam int PACKET_WORDS_DEF = 6;

  // Function codes
  localparam logic [2:0] FN_IO_WR  = 3'd0;
  localparam logic [2:0] FN_IO_RD  = 3'd1;
  localparam logic [2:0] FN_CTL_WR = 3'd2;
  localparam logic [2:0] FN_CTL_RD = 3'd3;
  localparam logic [2:0] FN_FILL   = 3'd4;

  // IO register offsets
  localparam logic [2:0] REG_DATA     = 3'd0;
  localparam logic [2:0] REG_FEATURES = 3'd1;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_LBA_LOW  = 3'd3;
  localparam logic [2:0] REG_LBA_MID  = 3'd4;
  localparam logic [2:0] REG_LBA_HIGH = 3'd5;
  localparam logic [2:0] REG_DRIVE    = 3'd6;
  localparam logic [2:0] REG_COMMAND  = 3'd7;

  // Configuration register indexes
  localparam logic CFG_CDROM_SIZE = 1'b0;
  localparam logic CFG_DISK_SIZE  = 1'b1;

  // Status and error bits
  localparam logic [7:0] ST_ERR    = 8'h01;
  localparam logic [7:0] ST_DRQ    = 8'h08;
  localparam logic [7:0] ST_RDY    = 8'h40;
  localparam logic [7:0] ST_BSY    = 8'h80;
  localparam logic [7:0] ERR_ABORT = 8'h04;
  localparam logic [7:0] DRIVE_HEAD_RESET = 8'hA0;
  localparam logic [7:0] DRIVE_FIXED_BITS = 8'hA0;
  localparam logic [7:0] CTL_SRST  = 8'h04;

  // Commands and packet opcodes
  localparam logic [7:0] CMD_NOP         = 8'h00;
  localparam logic [7:0] CMD_PACKET      = 8'hA0;
  localparam logic [7:0] CMD_IDENT_PKT   = 8'hA1;
  localparam logic [7:0] CMD_IDENT       = 8'hEC;
  localparam logic [7:0] OP_READ10       = 8'h28;
  localparam logic [7:0] OP_TEST_READY   = 8'h00;

  // Data sources
  localparam logic [1:0] SRC_BUFFER = 2'd0;
  localparam logic [1:0] SRC_CD_ID  = 2'd1;
  localparam logic [1:0] SRC_HD_ID  = 2'd2;

  // Identify page text, left aligned and padded with spaces
  localparam logic [319:0] CD_SERIAL = {"123456789", {31{8'h20}}};
  localparam logic [319:0] HD_SERIAL = {"987654321", {31{8'h20}}};
  localparam logic [319:0] FW_REV    = {"1.0", {37{8'h20}}};
  localparam logic [319:0] CD_MODEL  = {"ATAPI CD-ROM", {28{8'h20}}};
  localparam logic [319:0] HD_MODEL  = {"ATA Hard Drive", {26{8'h20}}};

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  reg_offset;
    logic [31:0] write_data;
    logic [2:0]  access_bytes;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        fatal;
    logic        media_request;
    logic [31:0] media_lba;
    logic [15:0] media_count;
  } out_t;

  // Two text characters per word, first character in the high byte
  function automatic logic [15:0] text_word(logic [319:0] s, logic [7:0] i);
    logic [5:0] p;
    p = {i[4:0], 1'b0};
    return {s[319 - 8 * p -: 8], s[311 - 8 * p -: 8]};
  endfunction

  function automatic logic [15:0] ident_word(logic cd, logic [7:0] w, logic [31:0] blocks);
    logic [15:0] r;
    r = 16'h0000;
    if (w == 8'd0) begin
      r = cd ? 16'h8580 : 16'h0040;
    end else if (w >= 8'd10 && w < 8'd20) begin
      r = text_word(cd ? CD_SERIAL : HD_SERIAL, w - 8'd10);
    end else if (w >= 8'd23 && w < 8'd27) begin
      r = text_word(FW_REV, w - 8'd23);
    end else if (w >= 8'd27 && w < 8'd47) begin
      r = text_word(cd ? CD_MODEL : HD_MODEL, w - 8'd27);
    end else if (w == 8'd47) begin
      r = 16'h8000;
    end else if (w == 8'd60) begin
      r = blocks[15:0];
    end else if (w == 8'd61) begin
      r = blocks[31:16];
    end else if (w == 8'd82 || w == 8'd85) begin
      r = 16'h7000;
    end
    return r;
  endfunction

endpackage

[rtl/atadr_ram.sv]
module atadr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/ata_atapi_device_registers_top.sv]
// An accepted item is registered while the data store is read; the register
// update and result are then registered from it. No new item is taken while
// one is in work or while a result is held by a stalled receiver.
// Reset clears all task-file and control registers; the data store and the
// command block hold no reset value and get no clearing pass.
module ata_atapi_device_registers_top
  import atadr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int PACKET_WORDS = PACKET_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int STORE_WORDS = BUFFER_BYTES / 2;
  localparam int WA = $clog2(STORE_WORDS);
  localparam int PB = $clog2(BUFFER_BYTES) + 1;
  localparam int PL = PACKET_WORDS * 2;
  localparam int PFW = $clog2(PL + 1);
  localparam logic [27:0] BUF_LIMIT = 28'(BUFFER_BYTES);
  localparam logic [WA:0] STORE_LIMIT = (WA + 1)'(STORE_WORDS);

  // Registers
  logic [31:0] cdrom_size, disk_size;
  logic [7:0]  status, error, count, lba_low, drive_head, dev_ctl;
  logic [1:0]  expect_mode;
  logic [7:0]  pkt [PL];
  logic [PFW-1:0] pkt_fill;
  logic [PB-1:0]  tlen, rpos;
  logic [WA:0]    fpos;
  logic [1:0]     src;
  logic           busy;
  in_t            item;

  logic [7:0]  status_next, error_next, count_next, lba_low_next, drive_head_next;
  logic [7:0]  dev_ctl_next;
  logic [1:0]  expect_next;
  logic [7:0]  pkt_next [PL];
  logic [PFW-1:0] pkt_fill_next;
  logic [PB-1:0]  tlen_next, rpos_next;
  logic [WA:0]    fpos_next;
  logic [1:0]     src_next;
  out_t           res;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = busy || (out_valid && out_stall);

  // Data store: even and odd word banks so three neighbor words read at once
  logic [WA-1:0] w0, w1, w2;
  logic [15:0]   ev_a, ev_b, od_a, od_b;
  logic          fill_we;
  logic [15:0]   word0, word1, word2;

  assign w0 = rpos[WA:1];
  assign w1 = w0 + 1'b1;
  assign w2 = w0 + 2'd2;
  assign fill_we = busy && (item.func == FN_FILL) && (fpos < STORE_LIMIT);

  atadr_ram #(.WIDTH(16), .DEPTH(STORE_WORDS / 2)) u_even (
    .clk(clk), .we(fill_we && !fpos[0]), .waddr(fpos[WA-1:1]),
    .wdata(item.write_data[15:0]),
    .raddr_a(w0[0] ? w1[WA-1:1] : w0[WA-1:1]), .raddr_b(w2[WA-1:1]),
    .rdata_a(ev_a), .rdata_b(ev_b)
  );

  atadr_ram #(.WIDTH(16), .DEPTH(STORE_WORDS / 2)) u_odd (
    .clk(clk), .we(fill_we && fpos[0]), .waddr(fpos[WA-1:1]),
    .wdata(item.write_data[15:0]),
    .raddr_a(w0[0] ? w0[WA-1:1] : w1[WA-1:1]), .raddr_b(w2[WA-1:1]),
    .rdata_a(od_a), .rdata_b(od_b)
  );

  assign word0 = w0[0] ? od_a : ev_a;
  assign word1 = w0[0] ? ev_a : od_a;
  assign word2 = w0[0] ? od_b : ev_b;

  // Source words for a data port read
  logic [7:0]  iw0;
  logic [31:0] cd_blocks, hd_blocks;
  logic [15:0] sw [3];
  logic [7:0]  sbytes [6];

  assign iw0 = rpos[8:1];
  assign cd_blocks = {11'd0, cdrom_size[31:11]};
  assign hd_blocks = {9'd0, disk_size[31:9]};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (src == SRC_CD_ID) begin
        sw[k] = ident_word(1'b1, iw0 + 8'(k), cd_blocks);
      end else if (src == SRC_HD_ID) begin
        sw[k] = ident_word(1'b0, iw0 + 8'(k), hd_blocks);
      end else begin
        sw[k] = (k == 0) ? word0 : ((k == 1) ? word1 : word2);
      end
      sbytes[2 * k]     = sw[k][7:0];
      sbytes[2 * k + 1] = sw[k][15:8];
    end
  end

  // Update and result
  logic [2:0]     nb, nrd;
  logic [PB-1:0]  rem, rpos_sum;
  logic [31:0]    rd_val;
  logic [PFW:0]   fill_end;
  logic [PFW:0]   kk;
  logic [7:0]     v;
  logic           disk;
  logic [31:0]    p_lba;
  logic [15:0]    p_cnt;
  logic [32:0]    p_end;
  logic [31:0]    p_limit;
  logic [27:0]    p_len;

  always_comb begin
    status_next = status;
    error_next = error;
    count_next = count;
    lba_low_next = lba_low;
    drive_head_next = drive_head;
    dev_ctl_next = dev_ctl;
    expect_next = expect_mode;
    pkt_next = pkt;
    pkt_fill_next = pkt_fill;
    tlen_next = tlen;
    rpos_next = rpos;
    fpos_next = fpos;
    src_next = src;
    res = '0;

    v = item.write_data[7:0];
    disk = drive_head[4];
    nb = (item.access_bytes > 3'd4) ? 3'd4 : item.access_bytes;
    rem = tlen - rpos;
    nrd = (rem < PB'(nb)) ? rem[2:0] : nb;
    rpos_sum = rpos + PB'(nrd);
    rd_val = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < nrd) begin
        rd_val[8 * k +: 8] = sbytes[3'(k) + {2'b00, rpos[0]}];
      end
    end

    // Command block gather
    fill_end = {1'b0, pkt_fill} + (PFW + 1)'(nb);
    for (int i = 0; i < PL; i++) begin
      kk = (PFW + 1)'(i) - {1'b0, pkt_fill};
      if ((PFW + 1)'(i) >= {1'b0, pkt_fill} && (PFW + 1)'(i) < fill_end) begin
        pkt_next[i] = item.write_data[8 * kk[1:0] +: 8];
      end
    end
    p_lba = {pkt_next[2], pkt_next[3], pkt_next[4], pkt_next[5]};
    p_cnt = {pkt_next[7], pkt_next[8]};
    p_end = {1'b0, p_lba} + 33'(p_cnt);
    p_limit = disk ? {9'd0, cdrom_size[31:9]} : {11'd0, cdrom_size[31:11]};
    p_len = disk ? {3'd0, p_cnt, 9'd0} : {1'b0, p_cnt, 11'd0};

    unique case (item.func)
      FN_IO_WR: begin
        unique case (item.reg_offset)
          REG_DATA: begin
            if (!status[3] || expect_mode != 2'd1) begin
              res.fatal = 1'b1;
            end else if (fill_end >= (PFW + 1)'(PL)) begin
              status_next = (status & ~ST_DRQ) | ST_BSY;
              pkt_fill_next = '0;
              if (pkt_next[0] == OP_READ10) begin
                if (p_end > {1'b0, p_limit}) begin
                  error_next = ERR_ABORT;
                  status_next = (status_next | ST_ERR) & ~ST_BSY;
                end else begin
                  tlen_next = (p_len > BUF_LIMIT) ? PB'(BUFFER_BYTES) : PB'(p_len);
                  src_next = SRC_BUFFER;
                  fpos_next = '0;
                  status_next = (status_next | ST_DRQ) & ~ST_BSY;
                  res.media_request = 1'b1;
                  res.media_lba = p_lba;
                  res.media_count = p_cnt;
                end
              end else if (pkt_next[0] == OP_TEST_READY) begin
                status_next = status_next & ~ST_BSY;
              end
            end else begin
              pkt_fill_next = fill_end[PFW-1:0];
            end
          end
          REG_FEATURES: res.fatal = (v != 8'd0);
          REG_COUNT: count_next = v;
          REG_LBA_LOW: lba_low_next = v;
          REG_LBA_MID, REG_LBA_HIGH: begin
          end
          REG_DRIVE: begin
            drive_head_next = v;
            res.fatal = ((v & DRIVE_FIXED_BITS) != DRIVE_FIXED_BITS);
          end
          default: begin
            if (v == CMD_NOP) begin
            end else if (v == CMD_IDENT_PKT || v == CMD_IDENT) begin
              if ((v == CMD_IDENT_PKT) == disk) begin
                error_next = ERR_ABORT;
                status_next = status | ST_ERR;
              end else begin
                expect_next = 2'd2;
                src_next = disk ? SRC_HD_ID : SRC_CD_ID;
                tlen_next = PB'(512);
                status_next = (status | ST_DRQ) & ~ST_BSY;
              end
            end else if (v == CMD_PACKET) begin
              if (disk) begin
                error_next = ERR_ABORT;
                status_next = status | ST_ERR;
              end else begin
                status_next = status | ST_DRQ;
                expect_next = 2'd1;
              end
            end else begin
              res.fatal = 1'b1;
            end
          end
        endcase
      end
      FN_IO_RD: begin
        unique case (item.reg_offset)
          REG_DATA: begin
            if (!status[3] || rpos >= tlen) begin
              res.fatal = 1'b1;
            end else begin
              res.read_data = rd_val;
              rpos_next = rpos_sum;
              if (rpos_sum == tlen) begin
                rpos_next = '0;
                tlen_next = '0;
                pkt_fill_next = '0;
                status_next = status & ~ST_DRQ;
              end
            end
          end
          REG_FEATURES: begin
            res.read_data = {24'd0, error};
            error_next = 8'd0;
            status_next = status & ~ST_ERR;
          end
          REG_COUNT: res.read_data = {24'd0, count};
          REG_LBA_LOW: res.read_data = {24'd0, lba_low};
          REG_DRIVE: res.read_data = {24'd0, drive_head};
          REG_COMMAND: res.read_data = {24'd0, status};
          default: res.fatal = 1'b1;
        endcase
      end
      FN_CTL_WR: begin
        if (item.reg_offset != 3'd0) begin
          res.fatal = 1'b1;
        end else begin
          // Soft reset on falling SRST
          if (dev_ctl[2] && !v[2]) begin
            status_next = ST_RDY;
            lba_low_next = 8'd0;
          end
          dev_ctl_next = v & 8'hFF;
        end
      end
      FN_CTL_RD: begin
        if (item.reg_offset != 3'd0) begin
          res.fatal = 1'b1;
        end else begin
          res.read_data = {24'd0, status};
        end
      end
      FN_FILL: begin
        if (fpos < STORE_LIMIT) begin
          fpos_next = fpos + 1'b1;
        end
      end
      default: res.fatal = 1'b1;
    endcase
  end

  // Control and task-file registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cdrom_size <= '0;
      disk_size <= '0;
      status <= ST_RDY;
      error <= '0;
      count <= '0;
      lba_low <= '0;
      drive_head <= DRIVE_HEAD_RESET;
      dev_ctl <= '0;
      expect_mode <= '0;
      pkt_fill <= '0;
      tlen <= '0;
      rpos <= '0;
      fpos <= '0;
      src <= SRC_BUFFER;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CDROM_SIZE) begin
          cdrom_size <= cfg_data;
        end else begin
          disk_size <= cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      busy <= accept;
      if (busy) begin
        status <= status_next;
        error <= error_next;
        count <= count_next;
        lba_low <= lba_low_next;
        drive_head <= drive_head_next;
        dev_ctl <= dev_ctl_next;
        expect_mode <= expect_next;
        pkt_fill <= pkt_fill_next;
        tlen <= tlen_next;
        rpos <= rpos_next;
        fpos <= fpos_next;
        src <= src_next;
        out_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (busy) begin
      pkt <= pkt_next;
      out_data <= res;
    end
  end

  // Checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("input taken while an item is in work");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy)
    else $error("accepted item not in work");
  a_busy_result: assert property (@(posedge clk) disable iff (rst) busy |=> out_valid)
    else $error("item in work gave no result");
  a_fatal_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.fatal) |-> (out_data.read_data == 32'd0 && !out_data.media_request))
    else $error("fatal result carries data");

endmodule

[bench/ata_atapi_device_registers_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, predicts each result and compares it field by field.
module ata_atapi_device_registers_checker
  import atadr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int STORE_WORDS = BUFFER_BYTES_DEF / 2;
  localparam int BLOCK_LEN   = PACKET_WORDS_DEF * 2;

  // Device state mirror
  logic [31:0] cd_size, hd_size;
  logic [7:0]  status, err, features, count, lba_lo, lba_mid, lba_hi, drive, devctl;
  logic [1:0]  mode;
  logic [7:0]  cmd_block [BLOCK_LEN];
  int          block_fill;
  logic [15:0] store [STORE_WORDS];
  int          xfer_len, rd_pos, fill_pos;
  logic [1:0]  source;

  out_t expected_results[$];
  int   results_seen;

  assign pending = expected_results.size();

  function automatic logic [7:0] char_at(string s, int p);
    return (p < s.len()) ? s[p] : 8'h20;
  endfunction

  function automatic logic [15:0] page_word(bit cd, int w);
    string serial, model;
    logic [31:0] blocks;
    int t;
    serial = cd ? "123456789" : "987654321";
    model  = cd ? "ATAPI CD-ROM" : "ATA Hard Drive";
    blocks = cd ? cd_size / 2048 : hd_size / 512;
    if (w == 0) return cd ? 16'h8580 : 16'h0040;
    if (w >= 10 && w < 20) begin
      t = 2 * (w - 10);
      return {char_at(serial, t), char_at(serial, t + 1)};
    end
    if (w >= 23 && w < 27) begin
      t = 2 * (w - 23);
      return {char_at("1.0", t), char_at("1.0", t + 1)};
    end
    if (w >= 27 && w < 47) begin
      t = 2 * (w - 27);
      return {char_at(model, t), char_at(model, t + 1)};
    end
    if (w == 47) return 16'h8000;
    if (w == 60) return blocks[15:0];
    if (w == 61) return blocks[31:16];
    if (w == 82 || w == 85) return 16'h7000;
    return 16'h0000;
  endfunction

  function automatic logic [7:0] data_byte(int b);
    logic [15:0] w;
    if (source == SRC_CD_ID) w = page_word(1'b1, (b >> 1) & 255);
    else if (source == SRC_HD_ID) w = page_word(1'b0, (b >> 1) & 255);
    else w = store[(b >> 1) % STORE_WORDS];
    return (b & 1) ? w[15:8] : w[7:0];
  endfunction

  function automatic void abort_cmd();
    err = ERR_ABORT;
    status |= ST_ERR;
  endfunction

  // Execute a complete command block
  function automatic void run_block(ref out_t r);
    int unsigned sect;
    logic [31:0] lba;
    logic [15:0] cnt;
    longint len;
    sect = drive[4] ? 512 : 2048;
    if (cmd_block[0] == OP_READ10) begin
      lba = {cmd_block[2], cmd_block[3], cmd_block[4], cmd_block[5]};
      cnt = {cmd_block[7], cmd_block[8]};
      if (longint'(lba) + longint'(cnt) > longint'(cd_size / sect)) begin
        abort_cmd();
        status &= ~ST_BSY;
      end else begin
        len = longint'(sect) * longint'(cnt);
        if (len > BUFFER_BYTES_DEF) len = BUFFER_BYTES_DEF;
        xfer_len = int'(len);
        source = SRC_BUFFER;
        fill_pos = 0;
        foreach (cmd_block[k]) cmd_block[k] = 8'h00;
        status |= ST_DRQ;
        status &= ~ST_BSY;
        r.media_request = 1'b1;
        r.media_lba = lba;
        r.media_count = cnt;
      end
    end else if (cmd_block[0] == OP_TEST_READY) begin
      status &= ~ST_BSY;
    end
  endfunction

  function automatic bit io_write(logic [2:0] off, logic [31:0] d, int nb, ref out_t r);
    logic [7:0] v;
    bit disk;
    v = d[7:0];
    disk = drive[4];
    case (off)
      REG_DATA: begin
        if (!(status & ST_DRQ) || mode != 2'd1) return 1'b1;
        for (int k = 0; k < nb; k++)
          if (block_fill < BLOCK_LEN) begin
            cmd_block[block_fill] = d[8*k +: 8];
            block_fill++;
          end
        if (block_fill >= BLOCK_LEN) begin
          status &= ~ST_DRQ;
          status |= ST_BSY;
          block_fill = 0;
          run_block(r);
        end
        return 1'b0;
      end
      REG_FEATURES: begin features = v; return v != 8'h00; end
      REG_COUNT:    begin count = v; return 1'b0; end
      REG_LBA_LOW:  begin lba_lo = v; return 1'b0; end
      REG_LBA_MID:  begin lba_mid = v; return 1'b0; end
      REG_LBA_HIGH: begin lba_hi = v; return 1'b0; end
      REG_DRIVE: begin
        drive = v;
        return (v & DRIVE_FIXED_BITS) != DRIVE_FIXED_BITS;
      end
      default: begin
        if (v == CMD_NOP) return 1'b0;
        if (v == CMD_IDENT_PKT || v == CMD_IDENT) begin
          if ((v == CMD_IDENT_PKT) == disk) begin
            abort_cmd();
            return 1'b0;
          end
          mode = 2'd2;
          source = disk ? SRC_HD_ID : SRC_CD_ID;
          xfer_len = 512;
          status |= ST_DRQ;
          status &= ~ST_BSY;
          return 1'b0;
        end
        if (v == CMD_PACKET) begin
          if (disk) begin
            abort_cmd();
            return 1'b0;
          end
          status |= ST_DRQ;
          mode = 2'd1;
          return 1'b0;
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit io_read(logic [2:0] off, int nb, ref out_t r);
    int n;
    case (off)
      REG_DATA: begin
        if (!(status & ST_DRQ) || rd_pos >= xfer_len) return 1'b1;
        n = (nb > xfer_len - rd_pos) ? xfer_len - rd_pos : nb;
        for (int k = 0; k < n; k++) r.read_data[8*k +: 8] = data_byte(rd_pos + k);
        rd_pos += n;
        if (rd_pos == xfer_len) begin
          rd_pos = 0;
          xfer_len = 0;
          block_fill = 0;
          status &= ~ST_DRQ;
        end
        return 1'b0;
      end
      REG_FEATURES: begin
        r.read_data = err;
        err = 8'h00;
        status &= ~ST_ERR;
        return 1'b0;
      end
      REG_COUNT:   begin r.read_data = count; return 1'b0; end
      REG_LBA_LOW: begin r.read_data = lba_lo; return 1'b0; end
      REG_DRIVE:   begin r.read_data = drive; return 1'b0; end
      REG_COMMAND: begin r.read_data = status; return 1'b0; end
      default: return 1'b1;
    endcase
  endfunction

  // Result of one bus access
  function automatic out_t predict_access(in_t a);
    out_t r;
    bit bad;
    int nb;
    r = '0;
    bad = 1'b0;
    nb = (a.access_bytes > 3'd4) ? 4 : int'(a.access_bytes);
    case (a.func)
      FN_IO_WR: bad = io_write(a.reg_offset, a.write_data, nb, r);
      FN_IO_RD: bad = io_read(a.reg_offset, nb, r);
      FN_CTL_WR: begin
        if (a.reg_offset != 3'd0) bad = 1'b1;
        else begin
          if ((devctl & CTL_SRST) && !(a.write_data[7:0] & CTL_SRST)) begin
            status = ST_RDY;
            lba_lo = 8'h00;
            lba_mid = 8'h00;
            lba_hi = 8'h00;
          end
          devctl = a.write_data[7:0];
        end
      end
      FN_CTL_RD: begin
        if (a.reg_offset != 3'd0) bad = 1'b1;
        else r.read_data = status;
      end
      FN_FILL: begin
        if (fill_pos < STORE_WORDS) begin
          store[fill_pos] = a.write_data[15:0];
          fill_pos++;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) r.read_data = '0;
    r.fatal = bad;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH result %0d %s: expected %h got %h", results_seen, field, want, got);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      cd_size = '0; hd_size = '0;
      status = ST_RDY; err = '0; features = '0; count = '0;
      lba_lo = '0; lba_mid = '0; lba_hi = '0;
      drive = DRIVE_HEAD_RESET; devctl = '0; mode = '0;
      block_fill = 0; xfer_len = 0; rd_pos = 0; fill_pos = 0;
      source = SRC_BUFFER;
      expected_results.delete();
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CDROM_SIZE) cd_size = cfg_data;
        else hd_size = cfg_data;
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_access(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("MISMATCH unexpected result %0d", results_seen);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.read_data !== e.read_data)
            report("read_data", e.read_data, out_data.read_data);
          if (out_data.fatal !== e.fatal) report("fatal", e.fatal, out_data.fatal);
          if (out_data.media_request !== e.media_request)
            report("media_request", e.media_request, out_data.media_request);
          if (out_data.media_lba !== e.media_lba)
            report("media_lba", e.media_lba, out_data.media_lba);
          if (out_data.media_count !== e.media_count)
            report("media_count", e.media_count, out_data.media_count);
        end
        results_seen++;
      end
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import atadr_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     STORE_WORDS = BUFFER_BYTES_DEF / 2;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;

  int          idle_in, idle_out;
  int          accesses, read10_cmds;
  longint      cycles;
  logic [31:0] cd_bytes;

  ata_atapi_device_registers_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ata_atapi_device_registers_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < idle_out);

  // Run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ata_atapi_device_registers_top test failed");
      $finish;
    end
  end

  // One bus access transfer, with an optional random gap first
  task automatic access(logic [2:0] f, logic [2:0] off, logic [31:0] d, logic [2:0] w);
    if ($urandom_range(0, 99) < idle_in) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{func: f, reg_offset: off, write_data: d, access_bytes: w};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accesses++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [2:0] any_width();
    return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
  endfunction

  task automatic set_reg(logic [2:0] off, logic [7:0] v);
    access(FN_IO_WR, off, {$urandom, v} >> 0 & 32'h0000_00FF | {24'($urandom), 8'h00}, 3'd1);
  endtask

  // Command block through the data port, random transfer widths
  task automatic send_block(logic [7:0] blk [12], bit extra);
    int pos;
    logic [31:0] d;
    logic [2:0] w;
    pos = 0;
    while (pos < 12) begin
      w = any_width();
      d = $urandom;
      for (int k = 0; k < 4; k++) if (pos + k < 12) d[8*k +: 8] = blk[pos + k];
      access(FN_IO_WR, REG_DATA, d, w);
      pos += (w > 3'd4) ? 4 : int'(w);
    end
    if (extra) access(FN_IO_WR, REG_DATA, $urandom, 3'd4);
  endtask

  task automatic drain(int n);
    repeat (n) access(FN_IO_RD, REG_DATA, $urandom, any_width());
  endtask

  // PACKET command carrying READ(10), test unit ready or another opcode
  task automatic packet_cmd(logic [7:0] op, logic [31:0] lba, logic [15:0] cnt, bit disk);
    logic [7:0] blk [12];
    foreach (blk[k]) blk[k] = 8'($urandom);
    blk[0] = op;
    {blk[2], blk[3], blk[4], blk[5]} = lba;
    {blk[7], blk[8]} = cnt;
    set_reg(REG_DRIVE, DRIVE_HEAD_RESET);
    set_reg(REG_COMMAND, CMD_PACKET);
    if (disk) set_reg(REG_DRIVE, 8'hB0);
    send_block(blk, $urandom_range(0, 7) == 0);
  endtask

  task automatic random_read10();
    logic [31:0] blocks, lba;
    logic [15:0] cnt;
    bit disk;
    disk = ($urandom_range(0, 3) == 0);
    blocks = cd_bytes / (disk ? 512 : 2048);
    case ($urandom_range(0, 9))
      0: cnt = 16'($urandom);
      1: cnt = 16'($urandom_range(16, 70));
      default: cnt = 16'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 5) == 0) lba = $urandom;
    else if (blocks > cnt) lba = $urandom_range(0, blocks - cnt + 1);
    else lba = $urandom_range(0, 2);
    packet_cmd(OP_READ10, lba, cnt, disk);
    read10_cmds++;
    repeat ($urandom_range(0, 6)) access(FN_FILL, 3'($urandom), $urandom, any_width());
    drain($urandom_range(1, 40));
  endtask

  task automatic random_identify();
    bit disk;
    disk = $urandom_range(0, 1);
    set_reg(REG_DRIVE, disk ? 8'hB0 : 8'hA0);
    if ($urandom_range(0, 4) == 0) set_reg(REG_COMMAND, disk ? CMD_IDENT_PKT : CMD_IDENT);
    else set_reg(REG_COMMAND, disk ? CMD_IDENT : CMD_IDENT_PKT);
    drain(($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 60));
  endtask

  task automatic random_noise();
    logic [2:0] f;
    f = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    if (f == FN_CTL_WR && $urandom_range(0, 1)) begin
      access(FN_CTL_WR, 3'd0, {$urandom} & ~32'hFF | 32'(CTL_SRST), 3'd1);
      access(FN_CTL_WR, 3'd0, $urandom & ~32'(CTL_SRST), 3'd1);
    end else begin
      access(f, 3'($urandom), $urandom, 3'($urandom));
    end
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    wait (pending == 0);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    if (idx == CFG_CDROM_SIZE) cd_bytes = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [7:0] blk [12];
    int goal;
    cycles = 0;
    accesses = 0;
    read10_cmds = 0;
    idle_in = 0;
    idle_out = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CDROM_SIZE;
    cfg_data = '0;
    cd_bytes = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Load the whole buffer so that no data read sees an unwritten word
    for (int i = 0; i < STORE_WORDS; i++) access(FN_FILL, REG_DATA, $urandom, 3'd2);

    write_cfg(CFG_CDROM_SIZE, 32'd2048 * 100);
    write_cfg(CFG_DISK_SIZE, 32'd512 * 70000);

    // Directed: bad functions and offsets, register extremes, commands
    access(FN_CTL_RD, 3'd0, '0, 3'd1);
    access(FN_CTL_RD, 3'd3, '0, 3'd1);
    access(FN_CTL_WR, 3'd7, 32'hFFFF_FFFF, 3'd7);
    access(3'd5, 3'd0, '0, 3'd1);
    access(3'd7, 3'd7, 32'hFFFF_FFFF, 3'd7);
    set_reg(REG_FEATURES, 8'hFF);
    set_reg(REG_FEATURES, 8'h00);
    set_reg(REG_DRIVE, 8'h00);
    access(FN_IO_RD, REG_LBA_MID, '0, 3'd1);
    access(FN_IO_RD, REG_LBA_HIGH, '0, 3'd1);
    set_reg(REG_COMMAND, 8'h55);
    access(FN_IO_WR, REG_DATA, 32'hFFFF_FFFF, 3'd4);
    access(FN_IO_RD, REG_DATA, '0, 3'd4);
    set_reg(REG_DRIVE, 8'hB0);
    set_reg(REG_COMMAND, CMD_PACKET);
    access(FN_IO_RD, REG_FEATURES, '0, 3'd1);
    set_reg(REG_COMMAND, CMD_IDENT);
    drain(300);
    packet_cmd(OP_TEST_READY, '0, '0, 1'b0);
    packet_cmd(8'h12, '0, '0, 1'b0);
    packet_cmd(OP_READ10, 32'd99, 16'd2, 1'b0);
    packet_cmd(OP_READ10, 32'd0, 16'd20, 1'b1);
    drain(5);
    access(FN_CTL_WR, 3'd0, 32'(CTL_SRST), 3'd1);
    access(FN_CTL_WR, 3'd0, 32'h0, 3'd1);
    access(FN_IO_RD, REG_COMMAND, '0, 3'd1);

    // Random phases with different idling and sizes
    for (int ph = 0; ph < 3; ph++) begin
      idle_in = (ph == 0) ? 31 : (ph == 1) ? 79 : 0;
      idle_out = (ph == 0) ? 79 : (ph == 1) ? 31 : 0;
      case (ph)
        0: begin
          write_cfg(CFG_CDROM_SIZE, 32'hFFFF_FFFF);
          write_cfg(CFG_DISK_SIZE, 32'h0);
        end
        1: begin
          write_cfg(CFG_CDROM_SIZE, 32'h0);
          write_cfg(CFG_DISK_SIZE, 32'hFFFF_FFFF);
        end
        default: begin
          write_cfg(CFG_CDROM_SIZE, $urandom_range(0, 32'h0100_0000));
          write_cfg(CFG_DISK_SIZE, $urandom);
        end
      endcase
      goal = accesses + 700;
      while (accesses < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: random_read10();
          4, 5:       random_identify();
          6:          packet_cmd(($urandom_range(0, 1)) ? OP_TEST_READY : 8'($urandom),
                                 $urandom, 16'($urandom), 1'b0);
          default:    repeat ($urandom_range(1, 6)) random_noise();
        endcase
      end
    end

    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("covered %0d bus accesses (%0d buffer preload), %0d READ(10) commands,",
             accesses, STORE_WORDS, read10_cmds);
    $display("identify pages of both drives, soft resets and illegal accesses in 3 phases");
    if (errors == 0) begin
      $display("ata_atapi_device_registers_top test passed");
    end else begin
      $display("ata_atapi_device_registers_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/atadr_pkg.sv
rtl/atadr_ram.sv
rtl/ata_atapi_device_registers_top.sv
bench/ata_atapi_device_registers_checker.sv
bench/tb.sv
